@@ rtl/core/emv_pkg.sv @@
// Shared constants and types for the element-wise median unit.
// No dependencies; compile first.
package emv_pkg;

  // Default sample width and the number of input vectors
  localparam int SAMPLE_WIDTH_DEFAULT = 32;
  localparam int NUM_SAMPLES          = 6;
  localparam int RANK_W               = $clog2(NUM_SAMPLES);

  // Configuration port layout
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int COUNT_W    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MEDIAN_MODE = CFG_IDX_W'(1);

  // Register reset value and count bounds
  localparam logic [COUNT_W-1:0] VECTOR_COUNT_RESET = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_MIN          = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX          = COUNT_W'(NUM_SAMPLES);

  // Rank selection handed from the front end to the merge stage
  typedef struct packed {
    logic [RANK_W-1:0] lo_rank;
    logic [RANK_W-1:0] hi_rank;
    logic              use_mean;
  } emv_sel_t;

endpackage

@@ rtl/core/emv_if.sv @@
// Channel interfaces of the element-wise median unit: samples, results, config.
// Depends on emv_pkg.
interface emv_sample_if import emv_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_0;
  logic signed [SAMPLE_WIDTH-1:0] sample_1;
  logic signed [SAMPLE_WIDTH-1:0] sample_2;
  logic signed [SAMPLE_WIDTH-1:0] sample_3;
  logic signed [SAMPLE_WIDTH-1:0] sample_4;
  logic signed [SAMPLE_WIDTH-1:0] sample_5;
  logic                           end_of_vector;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                  end_of_vector, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                  end_of_vector, output ready);
endinterface

interface emv_result_if import emv_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median_value;
  logic                           end_of_result;

  modport source (output valid, median_value, end_of_result, input ready);
  modport sink   (input valid, median_value, end_of_result, output ready);
endinterface

interface emv_cfg_if import emv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/emv_rank_lane.sv @@
// One ranking lane: finds the sorted position of its own sample among the active ones.
// Depends on emv_pkg.
module emv_rank_lane import emv_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
  parameter int LANE         = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] samples [NUM_SAMPLES],
  input  logic [NUM_SAMPLES-1:0]         active,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic [RANK_W-1:0]              rank,
  output logic                           live
);

  logic [RANK_W-1:0] rank_next;

  // Count active samples that sort ahead; equal values break ties by lane order
  always_comb begin
    rank_next = '0;
    for (int j = 0; j < NUM_SAMPLES; j++) begin
      if (j != LANE && active[j]) begin
        if ((samples[j] < samples[LANE]) || ((samples[j] == samples[LANE]) && (j < LANE))) begin
          rank_next = rank_next + RANK_W'(1);
        end
      end
    end
  end

  // Lane register
  always_ff @(posedge clk) begin
    if (en) begin
      value <= samples[LANE];
      rank  <= rank_next;
      live  <= active[LANE];
    end
  end

endmodule

@@ rtl/core/emv_merge.sv @@
// Merge stage: picks the lower and upper middle values out of the ranked lanes.
// Depends on emv_pkg.
module emv_merge import emv_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] values [NUM_SAMPLES],
  input  logic [RANK_W-1:0]              ranks  [NUM_SAMPLES],
  input  logic [NUM_SAMPLES-1:0]         live,
  input  emv_sel_t                       sel,
  output logic signed [SAMPLE_WIDTH-1:0] lo,
  output logic signed [SAMPLE_WIDTH-1:0] hi,
  output logic                           use_mean
);

  logic signed [SAMPLE_WIDTH-1:0] lo_next;
  logic signed [SAMPLE_WIDTH-1:0] hi_next;

  // Ranks of live lanes are unique, so each select is a one-hot mux
  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      if (live[i] && ranks[i] == sel.lo_rank) begin
        lo_next = values[i];
      end
      if (live[i] && ranks[i] == sel.hi_rank) begin
        hi_next = values[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo       <= lo_next;
      hi       <= hi_next;
      use_mean <= sel.use_mean;
    end
  end

endmodule

@@ rtl/core/elementwise_median_of_vectors_unit.sv @@
// Element-wise median of up to six vectors, one channel word per cycle.
// Pipeline: 3 stages (lanes, merge, output); an accepted word is registered in each in turn.
// Throughput: one word per cycle; the three-stage pipeline stalls as a whole
// only while the output register holds a word that is not taken.
// Reset (rst, synchronous): pipeline empties, vector_count = 3, low_median_mode = 0.
// Depends on emv_pkg, emv_if, emv_rank_lane and emv_merge.
module elementwise_median_of_vectors_unit import emv_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  emv_cfg_if.sink      cfg,
  emv_sample_if.sink   sample_ch,
  emv_result_if.source result_ch
);

  // Configuration registers
  logic [COUNT_W-1:0] vector_count;
  logic               low_median_mode;

  // Pipeline control
  logic adv;
  logic v1, v2, v3;
  logic e1, e2, e3;

  // Stage data
  logic signed [SAMPLE_WIDTH-1:0] samples    [NUM_SAMPLES];
  logic signed [SAMPLE_WIDTH-1:0] lane_value [NUM_SAMPLES];
  logic [RANK_W-1:0]              lane_rank  [NUM_SAMPLES];
  logic [NUM_SAMPLES-1:0]         lane_live;
  logic [NUM_SAMPLES-1:0]         active;
  logic [NUM_SAMPLES-1:0]         lo_match;
  logic [COUNT_W-1:0]             n_eff;
  emv_sel_t                       sel_next;
  emv_sel_t                       sel;
  logic signed [SAMPLE_WIDTH-1:0] mid_lo;
  logic signed [SAMPLE_WIDTH-1:0] mid_hi;
  logic                           mid_use_mean;
  logic signed [SAMPLE_WIDTH:0]   mid_sum;
  logic signed [SAMPLE_WIDTH-1:0] median_value;

  // Config write port, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_count    <= VECTOR_COUNT_RESET;
      low_median_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_VECTOR_COUNT:    vector_count    <= cfg.data[COUNT_W-1:0];
        REG_LOW_MEDIAN_MODE: low_median_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Whole pipe moves when the output register is free or being drained
  assign adv             = !v3 || result_ch.ready;
  assign sample_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= sample_ch.valid && sample_ch.ready;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1 <= sample_ch.end_of_vector;
      e2 <= e1;
      e3 <= e2;
    end
  end

  // Effective count: zero acts as one, seven as six
  always_comb begin
    if (vector_count < COUNT_MIN) begin
      n_eff = COUNT_MIN;
    end else if (vector_count > COUNT_MAX) begin
      n_eff = COUNT_MAX;
    end else begin
      n_eff = vector_count;
    end
  end

  // Middle ranks: lower is (n-1)/2, upper is n/2
  always_comb begin
    sel_next.lo_rank  = RANK_W'((n_eff - COUNT_W'(1)) >> 1);
    sel_next.hi_rank  = RANK_W'(n_eff >> 1);
    sel_next.use_mean = !n_eff[0] && !low_median_mode;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      active[i] = (COUNT_W'(i) < n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel <= sel_next;
    end
  end

  assign samples[0] = sample_ch.sample_0;
  assign samples[1] = sample_ch.sample_1;
  assign samples[2] = sample_ch.sample_2;
  assign samples[3] = sample_ch.sample_3;
  assign samples[4] = sample_ch.sample_4;
  assign samples[5] = sample_ch.sample_5;

  // Ranking lanes, one per input vector
  for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
    emv_rank_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .LANE         (g)
    ) u_lane (
      .clk     (clk),
      .en      (adv),
      .samples (samples),
      .active  (active),
      .value   (lane_value[g]),
      .rank    (lane_rank[g]),
      .live    (lane_live[g])
    );
  end

  // Merge of lane results into the two middle values
  emv_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk      (clk),
    .en       (adv),
    .values   (lane_value),
    .ranks    (lane_rank),
    .live     (lane_live),
    .sel      (sel),
    .lo       (mid_lo),
    .hi       (mid_hi),
    .use_mean (mid_use_mean)
  );

  // Floor mean without overflow: one extra bit, then drop the lsb
  assign mid_sum = {mid_lo[SAMPLE_WIDTH-1], mid_lo} + {mid_hi[SAMPLE_WIDTH-1], mid_hi};

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      median_value <= mid_use_mean ? mid_sum[SAMPLE_WIDTH:1] : mid_lo;
    end
  end

  assign result_ch.valid         = v3;
  assign result_ch.median_value  = median_value;
  assign result_ch.end_of_result = e3;

  // Lower-middle rank match, used by the checks below
  always_comb begin
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      lo_match[i] = lane_live[i] && (lane_rank[i] == sel.lo_rank);
    end
  end

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && !result_ch.ready) |-> !sample_ch.ready)
    else $error("input accepted while output word is stalled");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready) |=> v1)
    else $error("accepted word did not enter the rank stage");

  a_unique_lo_rank: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $onehot(lo_match))
    else $error("lower middle rank not held by exactly one lane");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_ch.valid)
    else $error("result valid right after reset");

endmodule
